FILE: rtl/chtr_pkg.sv
// Package: status codes, opcodes and widths shared by the hash table block.
package chtr_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned LenW = 4;
  localparam int unsigned ValW = 34;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

endpackage

FILE: rtl/chained_hash_table_with_replacement.sv
// Top level: chained hash table with replacement and a small sequencer.
//
// Usage: one request word enters on the in channel (in_valid_i / in_stall_o)
// with opcode, key, key length and value. One result word leaves on the out
// channel (out_valid_o / out_stall_i) with status, value and slot.
// The home slot is key_len modulo TABLE_SIZE, taken from a small constant table.
// Keys, lengths and values live in a memory with one read port; the sequencer
// reads one slot per cycle, and a chain walk compares one slot per cycle.
// An insert checks home; if home is taken it searches for a free slot, then
// copies home out and scans for its predecessor (home held by another
// chain) or walks to the chain tail; then it writes and is done. Find and
// delete walk the chain; deleting a chain head may first pull its successor.
// The block takes one request at a time; in_stall_o is high while busy or
// while a result is held. A finished result waits in the output register
// until out_stall_i is low; no request is taken meanwhile, and the next
// request is taken at the earliest in the cycle after the result leaves.
// Reset clears the used bits and the links (null) at once; key, length and
// value storage is not cleared and is read only for used slots.
module chained_hash_table_with_replacement #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             opcode_i,
  input  logic [chtr_pkg::KeyW-1:0] key_bytes_i,
  input  logic [chtr_pkg::LenW-1:0] key_len_i,
  input  logic [chtr_pkg::ValW-1:0] phone_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [chtr_pkg::ValW-1:0] found_value_o,
  output logic [3:0]             slot_index_o
);
  import chtr_pkg::*;

  localparam int unsigned SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned LW = SW + 1;  // link width, null = TABLE_SIZE
  localparam logic [LW-1:0] NIL = LW'(TABLE_SIZE);
  localparam int unsigned NLEN = 1 << LenW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HOME   = 4'd1;  // home data is valid
  localparam logic [3:0] S_FREE   = 4'd2;  // scan used bits for free slot
  localparam logic [3:0] S_PRED   = 4'd3;  // scan links for home's predecessor
  localparam logic [3:0] S_MOVE   = 4'd4;  // write home copy into free slot
  localparam logic [3:0] S_PUT    = 4'd5;  // write new record
  localparam logic [3:0] S_TAIL   = 4'd6;  // walk to chain tail
  localparam logic [3:0] S_RD     = 4'd7;  // issue read of cur
  localparam logic [3:0] S_CMP    = 4'd8;  // compare cur data
  localparam logic [3:0] S_PULLRD = 4'd9;  // wait read of successor
  localparam logic [3:0] S_PULL   = 4'd10; // copy successor into head
  localparam logic [3:0] S_DONE   = 4'd11;

  // home slot of every key length, reduced by repeated subtraction
  function automatic logic [NLEN*SW-1:0] home_lut_f();
    logic [NLEN*SW-1:0] lut;
    int unsigned v;
    lut = '0;
    for (int unsigned i = 0; i < NLEN; i++) begin
      v = i;
      while (v >= TABLE_SIZE) v = v - TABLE_SIZE;
      lut[i*SW +: SW] = SW'(v);
    end
    return lut;
  endfunction

  localparam logic [NLEN*SW-1:0] HOME_LUT = home_lut_f();

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    logic [ValW-1:0] val;
  } rec_t;

  // storage
  rec_t            mem_q [TABLE_SIZE];
  rec_t            rd_q;
  logic [TABLE_SIZE-1:0] used_q;
  logic [LW-1:0]   link_q [TABLE_SIZE];

  logic [3:0]      state_q, state_d;
  logic [1:0]      op_q;
  rec_t            req_q;
  logic [SW-1:0]   home_q;
  logic [LW-1:0]   cur_q, cur_d, prev_q, prev_d, fr_q, fr_d;
  logic [LW-1:0]   idx_q, idx_d;   // scan counter, may reach TABLE_SIZE
  logic [LW-1:0]   steps_q, steps_d;
  logic            out_valid_q;
  logic [2:0]      status_q, status_d;
  logic [ValW-1:0] fval_q, fval_d;
  logic [3:0]      slot_q, slot_d;

  // memory port controls
  logic            rd_en;
  logic [SW-1:0]   rd_addr;
  logic            wr_en;
  logic [SW-1:0]   wr_addr;
  rec_t            wr_data;
  logic            accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  function automatic logic [SW-1:0] home_of(input logic [LenW-1:0] l);
    return HOME_LUT[l*SW +: SW];
  endfunction

  function automatic logic req_q_op_find();
    return op_q == OP_FIND;
  endfunction

  // the one compare unit: key and length of the registered read
  logic matched;
  assign matched = used_q[cur_q[SW-1:0]] && rd_q.key == req_q.key && rd_q.len == req_q.len;

  logic [LW-1:0] nxt_cur;
  assign nxt_cur = (link_q[cur_q[SW-1:0]] < NIL) ? link_q[cur_q[SW-1:0]] : NIL;

  // link and used updates from the sequencer
  logic            lk_en;
  logic [SW-1:0]   lk_addr;
  logic [LW-1:0]   lk_data;
  logic            us_set, us_clr;
  logic [SW-1:0]   us_addr, us_addr2;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    fr_d     = fr_q;
    idx_d    = idx_q;
    steps_d  = steps_q;
    status_d = status_q;
    fval_d   = fval_q;
    slot_d   = slot_q;
    rd_en    = 1'b0;
    rd_addr  = cur_q[SW-1:0];
    wr_en    = 1'b0;
    wr_addr  = home_q;
    wr_data  = req_q;
    lk_en    = 1'b0;
    lk_addr  = home_q;
    lk_data  = NIL;
    us_set   = 1'b0;
    us_clr   = 1'b0;
    us_addr  = home_q;
    us_addr2 = home_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_en    = 1'b1;
          rd_addr  = home_of(key_len_i);
          cur_d    = LW'(home_of(key_len_i));
          prev_d   = NIL;
          steps_d  = '0;
          idx_d    = '0;
          status_d = ST_NOT_FOUND;
          fval_d   = '0;
          slot_d   = '0;
          unique case (opcode_i) inside
            OP_INSERT: state_d = S_HOME;
            OP_FIND, OP_DELETE: state_d = S_CMP;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_HOME: begin
        if (!used_q[home_q]) begin
          fr_d    = LW'(home_q);
          state_d = S_PUT;
        end else begin
          idx_d   = '0;
          state_d = S_FREE;
        end
      end
      // one used bit per cycle
      S_FREE: begin
        if (idx_q == NIL) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else if (!used_q[idx_q[SW-1:0]]) begin
          fr_d = idx_q;
          idx_d = '0;
          if (home_of(rd_q.len) != home_q) state_d = S_MOVE;
          else begin
            cur_d   = LW'(home_q);
            steps_d = LW'(1);
            state_d = S_TAIL;
          end
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = fr_q[SW-1:0];
        wr_data = rd_q;
        us_set  = 1'b1;
        us_addr = fr_q[SW-1:0];
        lk_en   = 1'b1;
        lk_addr = fr_q[SW-1:0];
        lk_data = link_q[home_q];
        state_d = S_PRED;
      end
      // one link per cycle; first one pointing at home is redirected
      S_PRED: begin
        if (idx_q == NIL) begin
          fr_d    = LW'(home_q);
          state_d = S_PUT;
        end else if (link_q[idx_q[SW-1:0]] == LW'(home_q)) begin
          lk_en   = 1'b1;
          lk_addr = idx_q[SW-1:0];
          lk_data = fr_q;
          fr_d    = LW'(home_q);
          state_d = S_PUT;
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      // follow links to the tail, then hook the free slot on
      S_TAIL: begin
        if (steps_q >= LW'(TABLE_SIZE) || nxt_cur == NIL) begin
          lk_en   = 1'b1;
          lk_addr = cur_q[SW-1:0];
          lk_data = fr_q;
          state_d = S_PUT;
        end else begin
          cur_d   = nxt_cur;
          steps_d = steps_q + LW'(1);
        end
      end
      // keep a self link that the tail hook just put on the free slot
      S_PUT: begin
        wr_en    = 1'b1;
        wr_addr  = fr_q[SW-1:0];
        us_set   = 1'b1;
        us_addr  = fr_q[SW-1:0];
        if (!(fr_q != LW'(home_q) && link_q[fr_q[SW-1:0]] == fr_q)) begin
          lk_en   = 1'b1;
          lk_addr = fr_q[SW-1:0];
          lk_data = NIL;
        end
        status_d = ST_INSERTED;
        slot_d   = 4'(fr_q);
        state_d  = S_DONE;
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (matched) begin
          if (req_q_op_find()) begin
            status_d = ST_FOUND;
            fval_d   = rd_q.val;
            slot_d   = 4'(cur_q);
            state_d  = S_DONE;
          end else begin
            status_d = ST_DELETED;
            if (prev_q != NIL) begin
              lk_en   = 1'b1;
              lk_addr = prev_q[SW-1:0];
              lk_data = link_q[cur_q[SW-1:0]];
              us_clr  = 1'b1;
              us_addr2 = cur_q[SW-1:0];
              slot_d  = 4'(cur_q);
              state_d = S_DONE;
            end else if (nxt_cur != NIL && nxt_cur != cur_q) begin
              rd_en   = 1'b1;
              rd_addr = nxt_cur[SW-1:0];
              fr_d    = nxt_cur;
              state_d = S_PULLRD;
            end else begin
              lk_en   = 1'b1;
              lk_addr = cur_q[SW-1:0];
              lk_data = NIL;
              us_clr  = 1'b1;
              us_addr2 = cur_q[SW-1:0];
              slot_d  = 4'(cur_q);
              state_d = S_DONE;
            end
          end
        end else if (steps_q + LW'(1) >= LW'(TABLE_SIZE) || nxt_cur == NIL) begin
          state_d = S_DONE;
        end else begin
          prev_d  = cur_q;
          cur_d   = nxt_cur;
          steps_d = steps_q + LW'(1);
          rd_addr = nxt_cur[SW-1:0];
          rd_en   = 1'b1;
        end
      end
      S_PULLRD: state_d = S_PULL;
      S_PULL: begin
        wr_en    = 1'b1;
        wr_addr  = cur_q[SW-1:0];
        wr_data  = rd_q;
        lk_en    = 1'b1;
        lk_addr  = cur_q[SW-1:0];
        lk_data  = link_q[fr_q[SW-1:0]];
        us_clr   = 1'b1;
        us_addr2 = fr_q[SW-1:0];
        slot_d   = 4'(fr_q);
        state_d  = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // used bits and links, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) link_q[i] <= NIL;
    end else begin
      if (us_set) used_q[us_addr] <= 1'b1;
      if (us_clr) begin
        used_q[us_addr2] <= 1'b0;
        // a used-bit clear also nulls the freed link unless overwritten this cycle
        if (!(lk_en && lk_addr == us_addr2)) link_q[us_addr2] <= NIL;
      end
      if (lk_en) link_q[lk_addr] <= lk_data;
    end
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      prev_q      <= NIL;
      fr_q        <= '0;
      idx_q       <= '0;
      steps_q     <= '0;
      op_q        <= '0;
      home_q      <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      fr_q    <= fr_d;
      idx_q   <= idx_d;
      steps_q <= steps_d;
      if (accept) begin
        op_q   <= opcode_i;
        home_q <= home_of(key_len_i);
      end
      if (state_q == S_DONE) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // hold request payload and result words
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.key <= key_bytes_i;
      req_q.len <= key_len_i;
      req_q.val <= phone_value_i;
    end
    status_q <= status_d;
    fval_q   <= fval_d;
    slot_q   <= slot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = fval_q;
  assign slot_index_o  = slot_q;

endmodule
